FILE: sv/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// shared types and constants of the line rasterizer: the walk descriptor
// handed from the classifier to the pixel walker, and the decision codes
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned DecW   = 11;

  typedef enum logic [1:0] {
    CondLe,
    CondGe,
    CondLt
  } lr_cond_e;

  typedef struct packed {
    logic [CoordW-1:0]      x0;
    logic [CoordW-1:0]      y0;
    logic [CoordW-1:0]      count;
    logic signed [DecW-1:0] d0;
    logic signed [DecW-1:0] inc_minor;
    logic signed [DecW-1:0] inc_hold;
    logic                   major_y;
    logic                   y_down;
    lr_cond_e               cond;
  } lr_desc_t;

endpackage

FILE: sv/line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// midpoint line rasterizer: one command with two endpoints in, the pixels of
// the line out in walk order, last one flagged
// flow: an accepted command is queued, loaded into the walker, and its pixels are
// registered into the output beat at one pixel per cycle while out_ready_i allows;
// a line has max(|dx|,|dy|)+1 pixels (up to 64); a two-entry queue buffers further commands
// reset: asynchronous active low, empties the queue, walker and output beat
// ----------------------------------------------------------------------------
module line_rasterizer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lr_pkg::CoordW-1:0] start_x_i,
  input  logic [lr_pkg::CoordW-1:0] start_y_i,
  input  logic [lr_pkg::CoordW-1:0] end_x_i,
  input  logic [lr_pkg::CoordW-1:0] end_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lr_pkg::CoordW-1:0] pixel_x_o,
  output logic [lr_pkg::CoordW-1:0] pixel_y_o,
  output logic                      last_pixel_o
);
  import lr_pkg::*;

  lr_desc_t new_desc, head_desc;
  logic     full, empty, pop;

  lr_front u_front (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .desc_o    (new_desc)
  );

  lr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (new_desc),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (head_desc)
  );

  assign in_ready_o = !full;

  lr_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (!empty),
    .desc_i       (head_desc),
    .desc_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

FILE: sv/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// classifies a line command: orders the endpoints, picks one of the four
// midpoint walks and works out the start decision value and increments
// ----------------------------------------------------------------------------
module lr_front (
  input  logic [lr_pkg::CoordW-1:0] start_x_i,
  input  logic [lr_pkg::CoordW-1:0] start_y_i,
  input  logic [lr_pkg::CoordW-1:0] end_x_i,
  input  logic [lr_pkg::CoordW-1:0] end_y_i,
  output lr_pkg::lr_desc_t          desc_o
);
  import lr_pkg::*;

  localparam int unsigned PadW = DecW - CoordW;

  logic [CoordW-1:0]      sx, sy, ex, ey;
  logic                   vertical;
  logic signed [DecW-1:0] dxs, dys, ndy;

  always_comb begin
    vertical = (start_x_i == end_x_i);
    if (vertical) begin
      sx = start_x_i;
      ex = end_x_i;
      sy = (start_y_i < end_y_i) ? start_y_i : end_y_i;
      ey = (start_y_i < end_y_i) ? end_y_i : start_y_i;
    end else if (start_x_i > end_x_i) begin
      sx = end_x_i;
      sy = end_y_i;
      ex = start_x_i;
      ey = start_y_i;
    end else begin
      sx = start_x_i;
      sy = start_y_i;
      ex = end_x_i;
      ey = end_y_i;
    end
    dxs = {{PadW{1'b0}}, ex} - {{PadW{1'b0}}, sx};
    dys = {{PadW{1'b0}}, ey} - {{PadW{1'b0}}, sy};
    ndy = -dys;

    desc_o.x0 = sx;
    desc_o.y0 = sy;
    if (dys > dxs || vertical) begin
      // steep rising, also vertical lines with dx of zero
      desc_o.count     = dys[CoordW-1:0];
      desc_o.d0        = dys - (dxs <<< 1);
      desc_o.inc_minor = (dys - dxs) <<< 1;
      desc_o.inc_hold  = -(dxs <<< 1);
      desc_o.major_y   = 1'b1;
      desc_o.y_down    = 1'b0;
      desc_o.cond      = CondLe;
    end else if (dys >= 0) begin
      desc_o.count     = dxs[CoordW-1:0];
      desc_o.d0        = (dys <<< 1) - dxs;
      desc_o.inc_minor = (dys - dxs) <<< 1;
      desc_o.inc_hold  = dys <<< 1;
      desc_o.major_y   = 1'b0;
      desc_o.y_down    = 1'b0;
      desc_o.cond      = CondGe;
    end else if (ndy <= dxs) begin
      desc_o.count     = dxs[CoordW-1:0];
      desc_o.d0        = (dys <<< 1) + dxs;
      desc_o.inc_minor = (dys + dxs) <<< 1;
      desc_o.inc_hold  = dys <<< 1;
      desc_o.major_y   = 1'b0;
      desc_o.y_down    = 1'b1;
      desc_o.cond      = CondLt;
    end else begin
      desc_o.count     = ndy[CoordW-1:0];
      desc_o.d0        = dys + (dxs <<< 1);
      desc_o.inc_minor = (dys + dxs) <<< 1;
      desc_o.inc_hold  = dxs <<< 1;
      desc_o.major_y   = 1'b1;
      desc_o.y_down    = 1'b1;
      desc_o.cond      = CondGe;
    end
  end

endmodule

FILE: sv/lr_fifo.sv
// ----------------------------------------------------------------------------
// lr_fifo
// two-entry descriptor queue between the classifier and the pixel walker
// ----------------------------------------------------------------------------
module lr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lr_pkg::lr_desc_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lr_pkg::lr_desc_t pop_data_o
);
  import lr_pkg::*;

  lr_desc_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: sv/lr_walker.sv
// ----------------------------------------------------------------------------
// lr_walker
// runs the midpoint decision walk of one descriptor into a registered output beat,
// one pixel per cycle while out_ready_i does not stall that beat
// ----------------------------------------------------------------------------
module lr_walker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      desc_valid_i,
  input  lr_pkg::lr_desc_t          desc_i,
  output logic                      desc_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lr_pkg::CoordW-1:0] pixel_x_o,
  output logic [lr_pkg::CoordW-1:0] pixel_y_o,
  output logic                      last_pixel_o
);
  import lr_pkg::*;

  logic                   busy_q;
  logic [CoordW-1:0]      x_q, y_q, cnt_q;
  logic signed [DecW-1:0] d_q, inc_minor_q, inc_hold_q;
  logic                   major_y_q, y_down_q;
  lr_cond_e               cond_q;
  logic                   out_valid_q, last_q;
  logic [CoordW-1:0]      px_q, py_q;

  logic              adv, last_step, load, minor;
  logic [CoordW-1:0] y_step;

  assign adv       = busy_q && (!out_valid_q || out_ready_i);
  assign last_step = (cnt_q == '0);
  assign load      = desc_valid_i && (!busy_q || (adv && last_step));
  assign desc_pop_o = load;

  always_comb begin
    case (cond_q)
      CondLe:  minor = (d_q <= 0);
      CondGe:  minor = (d_q >= 0);
      CondLt:  minor = (d_q < 0);
      default: minor = 1'b0;
    endcase
    y_step = y_down_q ? (y_q - CoordW'(1)) : (y_q + CoordW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q         <= desc_i.x0;
      y_q         <= desc_i.y0;
      cnt_q       <= desc_i.count;
      d_q         <= desc_i.d0;
      inc_minor_q <= desc_i.inc_minor;
      inc_hold_q  <= desc_i.inc_hold;
      major_y_q   <= desc_i.major_y;
      y_down_q    <= desc_i.y_down;
      cond_q      <= desc_i.cond;
    end else if (adv) begin
      cnt_q <= cnt_q - CoordW'(1);
      d_q   <= minor ? (d_q + inc_minor_q) : (d_q + inc_hold_q);
      if (major_y_q) begin
        y_q <= y_step;
        if (minor) begin
          x_q <= x_q + CoordW'(1);
        end
      end else begin
        x_q <= x_q + CoordW'(1);
        if (minor) begin
          y_q <= y_step;
        end
      end
    end
    if (adv) begin
      px_q   <= x_q;
      py_q   <= y_q;
      last_q <= last_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (adv && last_step) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_pixel_o = last_q;

endmodule
